/* src/pec_pkg.sv */
// Shared types and constants for the postfix expression evaluator.
// Used by the controller, the datapath, the divider and the top level.
package pec_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DATA_W = 32;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DIV_CNT_W = $clog2(DATA_W);

   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [DATA_W-1:0] EMPTY_VALUE = DATA_W'(CHAR_DOLLAR);
   localparam logic [3:0] DECIMAL_BASE = 4'd10;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_NONE
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POP_A,
      ST_POP_B,
      ST_POP_C,
      ST_EXEC,
      ST_DIV_WAIT,
      ST_PUSH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic digit;
      logic flush;
      logic pop;
      logic cap_v1;
      logic cap_v2;
      logic alu_load;
      logic div_start;
      logic div_load;
      logic push_res;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic   is_end;
      logic   is_digit;
      logic   is_space;
      op_type op;
      logic   v1_zero;
      logic   div_done;
      logic   out_free;
   } dp_status_type;

endpackage

/* src/pec_ram.sv */
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module pec_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/pec_div.sv */
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
// Depends on pec_pkg.
module pec_div
   import pec_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] numerator,
   input  logic [DATA_W-1:0] denominator,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    den_ff, den_in;
   logic [DATA_W:0]      trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         neg_in  = numerator[DATA_W-1] ^ denominator[DATA_W-1];
         quo_in  = numerator[DATA_W-1] ? (DATA_W'(0) - numerator) : numerator;
         den_in  = denominator[DATA_W-1] ? (DATA_W'(0) - denominator) : denominator;
      end else if (busy_ff) begin
         // restoring step: subtract when the shifted remainder covers the divisor
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;

endmodule

/* src/pec_dp.sv */
// Datapath: item register, number builder, operand stack, ALU, divider, result register.
// Depends on pec_pkg, pec_ram and pec_div.
module pec_dp
   import pec_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status,
   input  logic [7:0]           req_character,
   input  logic                 req_end_of_expression,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_result_value,
   output logic                 rsp_stack_was_empty,
   output logic                 rsp_overflow_seen,
   output logic                 rsp_divide_by_zero_seen
);

   logic [7:0]        char_ff, char_in;
   logic              end_ff, end_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              pending_ff, pending_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              divz_ff, divz_in;
   logic              pop_empty_ff, pop_empty_in;
   logic [DATA_W-1:0] v1_ff, v1_in;
   logic              v1_empty_ff, v1_empty_in;
   logic [DATA_W-1:0] v2_ff, v2_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_value_ff, out_value_in;
   logic              out_empty_ff, out_empty_in;
   logic              out_ovf_ff, out_ovf_in;
   logic              out_divz_ff, out_divz_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic [CNT_W-1:0]  count_dec;
   logic              push_en;
   logic              div_done;
   logic [DATA_W-1:0] div_quo;
   logic [DATA_W-1:0] popped;
   logic              out_free;
   op_type            op;

   pec_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pec_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.div_start),
      .numerator   (v2_ff),
      .denominator (v1_ff),
      .done        (div_done),
      .quotient    (div_quo)
   );

   always_comb begin
      unique case (char_ff)
         CHAR_PLUS:  op = OP_ADD;
         CHAR_MINUS: op = OP_SUB;
         CHAR_STAR:  op = OP_MUL;
         CHAR_SLASH: op = OP_DIV;
         default:    op = OP_NONE;
      endcase
   end

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign count_dec = count_ff - CNT_W'(1);
   assign rd_addr   = count_dec[IDX_W-1:0];
   assign wr_addr   = count_ff[IDX_W-1:0];
   assign popped    = pop_empty_ff ? EMPTY_VALUE : rd_data;

   always_comb begin
      char_in      = char_ff;
      end_in       = end_ff;
      acc_in       = acc_ff;
      pending_in   = pending_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      divz_in      = divz_ff;
      pop_empty_in = pop_empty_ff;
      v1_in        = v1_ff;
      v1_empty_in  = v1_empty_ff;
      v2_in        = v2_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_value_in = out_value_ff;
      out_empty_in = out_empty_ff;
      out_ovf_in   = out_ovf_ff;
      out_divz_in  = out_divz_ff;
      wr_en        = 1'b0;
      wr_data      = cmd.flush ? acc_ff : res_ff;
      push_en      = (cmd.flush && pending_ff) || cmd.push_res;

      if (cmd.load_item) begin
         char_in = req_character;
         end_in  = req_end_of_expression;
      end

      if (cmd.digit) begin
         // acc * 10 as two shifts and an add
         acc_in     = (acc_ff << 3) + (acc_ff << 1) + DATA_W'(char_ff - CHAR_ZERO);
         pending_in = 1'b1;
      end

      if (cmd.flush) begin
         acc_in     = '0;
         pending_in = 1'b0;
      end

      if (push_en) begin
         if (count_ff < CNT_W'(STACK_DEPTH)) begin
            wr_en    = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.pop) begin
         if (count_ff == '0) begin
            pop_empty_in = 1'b1;
         end else begin
            pop_empty_in = 1'b0;
            count_in     = count_dec;
         end
      end

      if (cmd.cap_v1) begin
         v1_in       = popped;
         v1_empty_in = pop_empty_ff;
      end
      if (cmd.cap_v2) begin
         v2_in = popped;
      end

      if (cmd.alu_load) begin
         unique case (op)
            OP_ADD:  res_in = v2_ff + v1_ff;
            OP_SUB:  res_in = v2_ff - v1_ff;
            OP_MUL:  res_in = v2_ff * v1_ff;
            OP_DIV: begin
               res_in  = '0;
               divz_in = 1'b1;
            end
            OP_NONE: res_in = res_ff;
         endcase
      end
      if (cmd.div_load) begin
         res_in = div_quo;
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_value_in = v1_ff;
         out_empty_in = v1_empty_ff;
         out_ovf_in   = ovf_ff;
         out_divz_in  = divz_ff;
         count_in     = '0;
         acc_in       = '0;
         pending_in   = 1'b0;
         ovf_in       = 1'b0;
         divz_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pending_ff   <= 1'b0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         divz_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         divz_ff      <= divz_in;
         out_valid_ff <= out_valid_in;
      end
      char_ff      <= char_in;
      end_ff       <= end_in;
      pop_empty_ff <= pop_empty_in;
      v1_ff        <= v1_in;
      v1_empty_ff  <= v1_empty_in;
      v2_ff        <= v2_in;
      res_ff       <= res_in;
      out_value_ff <= out_value_in;
      out_empty_ff <= out_empty_in;
      out_ovf_ff   <= out_ovf_in;
      out_divz_ff  <= out_divz_in;
   end

   always_comb begin
      status.is_end   = end_ff;
      status.is_digit = (char_ff >= CHAR_ZERO) && (char_ff <= CHAR_NINE);
      status.is_space = (char_ff == CHAR_SPACE);
      status.op       = op;
      status.v1_zero  = (v1_ff == '0);
      status.div_done = div_done;
      status.out_free = out_free;
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_result_value        = signed'(out_value_ff);
   assign rsp_stack_was_empty     = out_empty_ff;
   assign rsp_overflow_seen       = out_ovf_ff;
   assign rsp_divide_by_zero_seen = out_divz_ff;

endmodule

/* src/pec_ctrl.sv */
// Controller state machine: sequences decode, stack pops, ALU, divider, result load, push and emit.
// Depends on pec_pkg.
module pec_ctrl
   import pec_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!status.is_end && status.is_digit) begin
               cmd.digit = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               // any other item first pushes a pending number
               cmd.flush = 1'b1;
               if (!status.is_end && status.is_space) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_POP_A;
               end
            end
         end
         ST_POP_A: begin
            cmd.pop  = 1'b1;
            state_in = ST_POP_B;
         end
         ST_POP_B: begin
            cmd.cap_v1 = 1'b1;
            if (status.is_end) begin
               state_in = ST_EMIT;
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_POP_C;
            end
         end
         ST_POP_C: begin
            cmd.cap_v2 = 1'b1;
            state_in   = ST_EXEC;
         end
         ST_EXEC: begin
            priority if (status.op == OP_NONE) begin
               state_in = ST_IDLE;
            end else if (status.op == OP_DIV && !status.v1_zero) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_WAIT;
            end else begin
               cmd.alu_load = 1'b1;
               state_in     = ST_PUSH;
            end
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.div_load = 1'b1;
               state_in     = ST_PUSH;
            end
         end
         ST_PUSH: begin
            cmd.push_res = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* src/postfix_expression_evaluator.sv */
// Postfix expression evaluator: one ASCII character per input item.
// Input channel req_*: req_character and req_end_of_expression, taken when
//   req_valid is high and req_stall is low. req_stall is high while an item
//   is being worked on; the block works on one item at a time.
// Result channel rsp_*: one result per end item, held in an output register
//   until taken (rsp_valid high, rsp_stall low). A waiting result does not
//   block further items; only a second end item waits for the register.
// Per item: a digit or space is decoded and done; an operator + - * or /
//   pops two operands, computes and pushes the result (division waits for
//   the iterative divider; divide by zero pushes zero); other characters
//   pop two operands and push nothing; an end item pops one value and emits
//   it when the output register is free. The operand stack sits in a
//   single-port-read memory with registered read.
// Reset (synchronous, active high) empties the stack, clears the number
//   builder and error flags and drops any waiting result. Stack contents are
//   not cleared; only entries below the count are ever used.
// Depends on pec_pkg, pec_ctrl and pec_dp.
module postfix_expression_evaluator
   import pec_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_character,
   input  logic               req_end_of_expression,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_stack_was_empty,
   output logic               rsp_overflow_seen,
   output logic               rsp_divide_by_zero_seen
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   pec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pec_dp u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_character           (req_character),
      .req_end_of_expression   (req_end_of_expression),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_result_value        (rsp_result_value),
      .rsp_stack_was_empty     (rsp_stack_was_empty),
      .rsp_overflow_seen       (rsp_overflow_seen),
      .rsp_divide_by_zero_seen (rsp_divide_by_zero_seen)
   );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for postfix_expression_evaluator: feeds characters and end
// items, evaluates each expression alongside the block and compares every answer.
// Depends on pec_pkg and the postfix_expression_evaluator RTL.
`timescale 1ns / 100ps

module tb_top
   import pec_pkg::*;
;

   localparam logic [7:0] CHAR_CARET = 8'h5E;
   localparam int RANDOM_ITEMS = 750;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_ITEMS = 80;
   localparam int SETTLE_CYCLES = 60;

   typedef struct {
      logic [7:0] ch;
      logic       eoe;
      bit         hold;
   } key_item_type;

   typedef struct {
      logic signed [31:0] value;
      logic               empty;
      logic               ovf;
      logic               dz;
   } answer_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_character = 8'h00;
   logic               req_end_of_expression = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_result_value;
   logic               rsp_stack_was_empty;
   logic               rsp_overflow_seen;
   logic               rsp_divide_by_zero_seen;

   key_item_type queued_keys[$];
   answer_type   pending_answers[$];
   bit           drain_next = 1'b0;

   // evaluator shadow state
   logic [31:0] calc_stack [STACK_DEPTH];
   int unsigned calc_depth;
   logic [31:0] num_acc;
   logic        num_pending;
   logic        ovf_flag;
   logic        dz_flag;

   bit          req_taken = 1'b0;
   bit          tail_mode = 1'b0;
   int unsigned send_gap_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned sent_count = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;

   postfix_expression_evaluator uut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_character           (req_character),
      .req_end_of_expression   (req_end_of_expression),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_result_value        (rsp_result_value),
      .rsp_stack_was_empty     (rsp_stack_was_empty),
      .rsp_overflow_seen       (rsp_overflow_seen),
      .rsp_divide_by_zero_seen (rsp_divide_by_zero_seen)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ---------------- evaluator ----------------

   function automatic void clear_expression();
      calc_depth = 0;
      num_acc = '0;
      num_pending = 1'b0;
      ovf_flag = 1'b0;
      dz_flag = 1'b0;
   endfunction

   function automatic void push_operand(input logic [31:0] v);
      if (calc_depth >= STACK_DEPTH) begin
         ovf_flag = 1'b1;
      end else begin
         calc_stack[calc_depth] = v;
         calc_depth++;
      end
   endfunction

   function automatic logic [31:0] pop_operand(output logic was_empty);
      was_empty = (calc_depth == 0);
      if (was_empty) return EMPTY_VALUE;
      calc_depth--;
      return calc_stack[calc_depth];
   endfunction

   function automatic void flush_number();
      if (num_pending) begin
         push_operand(num_acc);
         num_acc = '0;
         num_pending = 1'b0;
      end
   endfunction

   // divide on magnitudes so the most negative value over minus one wraps
   function automatic logic [31:0] quotient_toward_zero(input logic [31:0] num,
                                                        input logic [31:0] den);
      logic [31:0] un, ud, q;
      un = num[31] ? 32'd0 - num : num;
      ud = den[31] ? 32'd0 - den : den;
      q = un / ud;
      return (num[31] != den[31]) ? 32'd0 - q : q;
   endfunction

   task automatic evaluate_key(input logic [7:0] ch, input logic eoe);
      logic [31:0] v1, v2;
      logic        was_empty;
      answer_type  ans;
      if (eoe) begin
         flush_number();
         ans.value = pop_operand(was_empty);
         ans.empty = was_empty;
         ans.ovf = ovf_flag;
         ans.dz = dz_flag;
         pending_answers.push_back(ans);
         clear_expression();
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         num_acc = num_acc * DECIMAL_BASE + 32'(ch - CHAR_ZERO);
         num_pending = 1'b1;
      end else begin
         flush_number();
         if (ch != CHAR_SPACE) begin
            v1 = pop_operand(was_empty);
            v2 = pop_operand(was_empty);
            case (ch)
               CHAR_PLUS:  push_operand(v2 + v1);
               CHAR_MINUS: push_operand(v2 - v1);
               CHAR_STAR:  push_operand(v2 * v1);
               CHAR_SLASH: begin
                  if (v1 == 32'd0) begin
                     dz_flag = 1'b1;
                     push_operand(32'd0);
                  end else begin
                     push_operand(quotient_toward_zero(v2, v1));
                  end
               end
               default: ;
            endcase
         end
      end
   endtask

   // ---------------- stimulus builders ----------------

   task automatic add_key(input logic [7:0] ch, input logic eoe = 1'b0);
      key_item_type k;
      k.ch = ch;
      k.eoe = eoe;
      k.hold = drain_next;
      drain_next = 1'b0;
      queued_keys.push_back(k);
   endtask

   task automatic add_end();
      add_key(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic add_number(input logic [31:0] v);
      logic [7:0] digits[$];
      do begin
         digits.push_front(CHAR_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (digits[i]) add_key(digits[i]);
   endtask

   // more digits than fit in 32 bits, so the accumulator wraps
   task automatic add_long_digits();
      int unsigned len;
      len = $urandom_range(11, 14);
      add_key(CHAR_ZERO + 8'($urandom_range(1, 9)));
      repeat (len - 1) add_key(CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic add_operand();
      case ($urandom_range(0, 9))
         0: add_number(32'd0);
         1: add_number($urandom);
         2: add_number($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000);
         3: add_long_digits();
         default: add_number($urandom_range(1, 99));
      endcase
   endtask

   function automatic logic [7:0] pick_operator();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 5) return CHAR_PLUS;
      if (r < 10) return CHAR_MINUS;
      if (r < 15) return CHAR_STAR;
      if (r < 19) return CHAR_SLASH;
      return CHAR_CARET;
   endfunction

   task automatic add_min_by_minus_one();
      add_number(32'h8000_0000);
      add_key(CHAR_SPACE);
      add_key(CHAR_ZERO);
      add_key(CHAR_SPACE);
      add_key(CHAR_ZERO + 8'd1);
      add_key(CHAR_MINUS);
      add_key(CHAR_SLASH);
      add_end();
   endtask

   task automatic add_rpn();
      int unsigned operands, used, depth;
      bit          after_number;
      operands = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
      used = 0;
      depth = 0;
      after_number = 1'b0;
      while (used < operands || depth > 1) begin
         if (used < operands && (depth < 2 || $urandom_range(0, 1) == 1)) begin
            if (after_number) repeat ($urandom_range(1, 2)) add_key(CHAR_SPACE);
            add_operand();
            used++;
            depth++;
            after_number = 1'b1;
         end else begin
            if ($urandom_range(0, 1) == 1) add_key(CHAR_SPACE);
            add_key(pick_operator());
            depth--;
            after_number = 1'b0;
         end
      end
      add_end();
   endtask

   // random mix of bytes, operators and numbers: underflow and junk
   task automatic add_broken();
      repeat ($urandom_range(1, 8)) begin
         case ($urandom_range(0, 2))
            0: add_key(8'($urandom_range(0, 255)));
            1: add_key(pick_operator());
            default: begin
               add_operand();
               add_key(CHAR_SPACE);
            end
         endcase
      end
      add_end();
   endtask

   task automatic add_deep_stack(input int unsigned pushes);
      repeat (pushes) begin
         add_number($urandom_range(0, 9));
         add_key(CHAR_SPACE);
      end
      if ($urandom_range(0, 1) == 1) add_key(pick_operator());
      add_end();
   endtask

   // ---------------- driver ----------------

   always @(negedge clock) begin
      key_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // stalled item stays put
      end else if (queued_keys.size() == 0) begin
         req_valid <= 1'b0;
      end else if (queued_keys[0].hold && pending_answers.size() != 0) begin
         req_valid <= 1'b0;
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (!tail_mode && $urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         gap_left <= $urandom_range(0, 14);
      end else begin
         nxt = queued_keys.pop_front();
         req_valid <= 1'b1;
         req_character <= nxt.ch;
         req_end_of_expression <= nxt.eoe;
         sent_count++;
         if (sent_count % 40 == 0) begin
            send_gap_pct <= $urandom_range(0, 1) ? 0 : $urandom_range(5, 50);
            recv_stall_pct <= $urandom_range(0, 1) ? 0 : $urandom_range(5, 50);
         end
         tail_mode <= (queued_keys.size() < TAIL_ITEMS);
      end
   end

   // result side backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!tail_mode && $urandom_range(0, 99) < recv_stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      answer_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (reset) begin
         clear_expression();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               $error("result item with none expected: result_value %0d", rsp_result_value);
               mismatch_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_result_value !== want.value) begin
                  $error("result_value: expected %0d, actual %0d", want.value,
                         rsp_result_value);
                  mismatch_count++;
               end
               if (rsp_stack_was_empty !== want.empty) begin
                  $error("stack_was_empty: expected %0b, actual %0b", want.empty,
                         rsp_stack_was_empty);
                  mismatch_count++;
               end
               if (rsp_overflow_seen !== want.ovf) begin
                  $error("overflow_seen: expected %0b, actual %0b", want.ovf,
                         rsp_overflow_seen);
                  mismatch_count++;
               end
               if (rsp_divide_by_zero_seen !== want.dz) begin
                  $error("divide_by_zero_seen: expected %0b, actual %0b", want.dz,
                         rsp_divide_by_zero_seen);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) evaluate_key(req_character, req_end_of_expression);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------- sequence ----------------

   initial begin
      int unsigned directed_n, pick;

      // empty expression
      add_end();
      add_min_by_minus_one();
      // character extremes, operators on an empty stack, divide by zero
      add_key(8'h00);
      add_key(8'hFF);
      add_key(CHAR_PLUS);
      add_key(CHAR_STAR);
      add_key(CHAR_CARET);
      add_key(CHAR_ZERO);
      add_key(CHAR_SLASH);
      add_end();
      directed_n = queued_keys.size();

      drain_next = 1'b1;
      add_deep_stack(STACK_DEPTH + 2);
      while (queued_keys.size() < directed_n + RANDOM_ITEMS) begin
         if ($urandom_range(0, 19) == 0) drain_next = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 66) add_rpn();
         else if (pick < 86) add_broken();
         else if (pick < 94) add_end();
         else if (pick < 99) add_min_by_minus_one();
         else add_deep_stack($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 4));
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (queued_keys.size() != 0 || req_valid) @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      // a trailing division may still be running
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
src/pec_pkg.sv
src/pec_ram.sv
src/pec_div.sv
src/pec_dp.sv
src/pec_ctrl.sv
src/postfix_expression_evaluator.sv
tb/sv/tb_top.sv
